FILE: design/lqs_pkg.sv
package lqs_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int DATA_W    = 32;

    typedef enum logic [1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_SEARCH = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_e_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } state_e_t;

    // row control: load writes the selected cell, shift moves every cell one
    // place towards the head, wrap closes the selected cell onto the head cell
    typedef struct packed {
        logic load;
        logic shift;
        logic wrap;
    } cell_ctrl_t;

endpackage

FILE: design/lqs_cell.sv
module lqs_cell #(
    parameter int DEPTH = lqs_pkg::DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  logic                       clk,
    input  lqs_pkg::cell_ctrl_t        ctrl,
    input  logic [$clog2(DEPTH)-1:0]   sel_idx,
    input  logic [lqs_pkg::DATA_W-1:0] wr_val,
    input  logic [lqs_pkg::DATA_W-1:0] next_val,
    input  logic [lqs_pkg::DATA_W-1:0] wrap_val,
    output logic [lqs_pkg::DATA_W-1:0] q
);
    import lqs_pkg::*;

    localparam int IW = $clog2(DEPTH);

    logic [DATA_W-1:0] q_reg;
    logic [DATA_W-1:0] q_next;
    logic              selected;

    assign selected = (sel_idx == IW'(IDX));

    always_comb
    begin
        q_next = q_reg;
        if (ctrl.load && selected)
        begin
            q_next = wr_val;
        end
        else if (ctrl.shift)
        begin
            q_next = (ctrl.wrap && selected) ? wrap_val : next_val;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

FILE: design/lqs_ctrl.sv
module lqs_ctrl #(
    parameter int DEPTH = lqs_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic [1:0]                        command,
    input  logic signed [lqs_pkg::DATA_W-1:0] value,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [1:0]                        status,
    output logic signed [lqs_pkg::DATA_W-1:0] data,
    output logic [$clog2(DEPTH)-1:0]          position,
    output logic [$clog2(DEPTH+1)-1:0]        occupancy,
    input  logic [lqs_pkg::DATA_W-1:0]        head_val,
    output lqs_pkg::cell_ctrl_t               cell_ctrl,
    output logic [$clog2(DEPTH)-1:0]          sel_idx
);
    import lqs_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_e_t          state_reg, state_next;
    logic [IW-1:0]     head_reg, head_next;
    logic [CW-1:0]     used_reg, used_next;
    logic              res_valid_reg, res_valid_next;

    logic [DATA_W-1:0] key_reg, key_next;
    logic [IW-1:0]     step_reg, step_next;
    logic              found_reg, found_next;
    status_e_t         pend_status_reg, pend_status_next;
    logic [DATA_W-1:0] pend_data_reg, pend_data_next;
    logic [IW-1:0]     pend_pos_reg, pend_pos_next;

    status_e_t         status_reg, status_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [IW-1:0]     position_reg, position_next;
    logic [CW-1:0]     occupancy_reg, occupancy_next;

    logic [CW-1:0]     occ;
    logic              full;
    logic              empty;
    logic              hit;
    logic [IW-1:0]     last_idx;

    assign occ      = used_reg - CW'(head_reg);
    assign full     = (used_reg == CW'(DEPTH));
    assign empty    = (occ == '0);
    assign hit      = (head_val == key_reg);
    assign last_idx = IW'(occ - CW'(1));

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        used_next        = used_reg;
        res_valid_next   = res_valid_reg && res_stall;
        key_next         = key_reg;
        step_next        = step_reg;
        found_next       = found_reg;
        pend_status_next = pend_status_reg;
        pend_data_next   = pend_data_reg;
        pend_pos_next    = pend_pos_reg;
        status_next      = status_reg;
        data_next        = data_reg;
        position_next    = position_reg;
        occupancy_next   = occupancy_reg;
        cell_ctrl        = '0;
        sel_idx          = IW'(occ);

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    pend_status_next = ST_OK;
                    pend_data_next   = '0;
                    pend_pos_next    = '0;
                    state_next       = S_DONE;
                    unique case (command)
                        CMD_ENQ:
                        begin
                            if (full)
                            begin
                                pend_status_next = ST_FULL;
                            end
                            else
                            begin
                                cell_ctrl.load = 1'b1;
                                used_next      = used_reg + CW'(1);
                            end
                        end
                        CMD_DEQ:
                        begin
                            if (empty)
                            begin
                                pend_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                pend_data_next  = head_val;
                                cell_ctrl.shift = 1'b1;
                                // drained: both indices go back to the first slot
                                if (CW'(head_reg) + CW'(1) >= used_reg)
                                begin
                                    head_next = '0;
                                    used_next = '0;
                                end
                                else
                                begin
                                    head_next = head_reg + IW'(1);
                                end
                            end
                        end
                        CMD_PEEK:
                        begin
                            if (empty)
                            begin
                                pend_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                pend_data_next = head_val;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            if (empty)
                            begin
                                pend_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                key_next   = value;
                                step_next  = '0;
                                found_next = 1'b0;
                                state_next = S_SEARCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                // rotate the held entries once past the head cell
                cell_ctrl.shift = 1'b1;
                cell_ctrl.wrap  = 1'b1;
                sel_idx         = last_idx;
                if (!found_reg && hit)
                begin
                    found_next    = 1'b1;
                    pend_pos_next = step_reg;
                end
                step_next = step_reg + IW'(1);
                if (step_reg == last_idx)
                begin
                    pend_status_next = (found_reg || hit) ? ST_OK : ST_NOTFOUND;
                    state_next       = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    status_next    = pend_status_reg;
                    data_next      = pend_data_reg;
                    position_next  = pend_pos_reg;
                    occupancy_next = occ;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            used_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            used_reg      <= used_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        step_reg        <= step_next;
        found_reg       <= found_next;
        pend_status_reg <= pend_status_next;
        pend_data_reg   <= pend_data_next;
        pend_pos_reg    <= pend_pos_next;
        status_reg      <= status_next;
        data_reg        <= data_next;
        position_reg    <= position_next;
        occupancy_reg   <= occupancy_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign position  = position_reg;
    assign occupancy = occupancy_reg;

    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg == '0 && head_reg == '0) || (CW'(head_reg) < used_reg))
        else $error("head index not below end index");

    a_search_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> !empty && (CW'(step_reg) < occ))
        else $error("search step outside held entries");

    a_enq_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && cmd_valid && command == CMD_ENQ && !full)
        |=> used_reg == $past(used_reg) + CW'(1))
        else $error("enqueue transfer did not advance end index");

    a_deq_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && cmd_valid && command == CMD_DEQ && !empty)
        |=> occ == $past(occ) - CW'(1))
        else $error("dequeue transfer did not drop one entry");

    a_search_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |=> $stable(head_reg) && $stable(used_reg))
        else $error("indices changed during search");

endmodule

FILE: design/linear_queue_with_search.sv
// Array queue of signed 32-bit words held in a row of DEPTH cells, cell 0
// always holding the head entry. Enqueue, dequeue and peek pass from the idle
// state through the done state into the registered result; a search first
// rotates the held entries once past the comparator at the head cell, one
// entry per cycle, before the done state. One command is worked on at a time; a
// new command is taken while the previous result still waits in the output
// register. The queue is not circular: once DEPTH enqueues have been made
// without the queue draining it reports full. No clearing pass follows reset.
module linear_queue_with_search #(
    parameter int DEPTH = lqs_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic [1:0]                        command,
    input  logic signed [lqs_pkg::DATA_W-1:0] value,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [1:0]                        status,
    output logic signed [lqs_pkg::DATA_W-1:0] data,
    output logic [$clog2(DEPTH)-1:0]          position,
    output logic [$clog2(DEPTH+1)-1:0]        occupancy
);
    import lqs_pkg::*;

    localparam int IW = $clog2(DEPTH);

    cell_ctrl_t        cell_ctrl;
    logic [IW-1:0]     sel_idx;
    logic [DATA_W-1:0] cell_q [DEPTH];

    lqs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .command   (command),
        .value     (value),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .data      (data),
        .position  (position),
        .occupancy (occupancy),
        .head_val  (cell_q[0]),
        .cell_ctrl (cell_ctrl),
        .sel_idx   (sel_idx)
    );

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [DATA_W-1:0] next_val;

        if (k < DEPTH - 1)
        begin : g_mid
            assign next_val = cell_q[k+1];
        end
        else
        begin : g_end
            assign next_val = cell_q[0];
        end

        lqs_cell #(
            .DEPTH (DEPTH),
            .IDX   (k)
        ) u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl),
            .sel_idx  (sel_idx),
            .wr_val   (value),
            .next_val (next_val),
            .wrap_val (cell_q[0]),
            .q        (cell_q[k])
        );
    end

endmodule
